@@ hdl/pnet_pkg.sv @@
// Package for the polyphonic note event tracker.
// Holds item kind codes, note range constants and the command broadcast to the slot cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pnet_pkg;

	typedef enum logic [1:0] {
		KIND_FRAME_START = 2'd0,
		KIND_NOTE        = 2'd1,
		KIND_FRAME_END   = 2'd2,
		KIND_FLUSH       = 2'd3
	} kind_t;

	localparam logic [6:0] NOTE_LOW  = 7'd21;
	localparam logic [6:0] NOTE_HIGH = 7'd108;

	typedef struct packed {
		logic        clr_seen;
		logic        note_op;
		logic        alloc;
		logic        silent;
		logic        flush;
		logic [6:0]  note;
		logic [7:0]  hold;
		logic [31:0] frame_time;
		logic [31:0] sweep_time;
		logic [31:0] min_len;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/pnet_cell.sv @@
// One slot of the active note table, a cell of the chain.
// Passes the free, match and pending-event chains and the sweep token to its neighbors.
// Depends on pnet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnet_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire pnet_pkg::cell_cmd_t cmd,
	input  wire                     tok_take,
	input  wire                     adv,
	input  wire                     free_in,
	output logic                    free_out,
	input  wire                     match_in,
	output logic                    match_out,
	input  wire                     later_in,
	output logic                    later_out,
	output logic                    tok,
	output logic                    emit,
	output logic [6:0]              note
);
	import pnet_pkg::*;

	logic        valid_q;
	logic        seen_q;
	logic        tok_q;
	logic [6:0]  note_q;
	logic [31:0] start_q;
	logic [8:0]  hold_q;

	logic        match;
	logic        first_free;
	logic        miss;
	logic [8:0]  hold_dec;
	logic        close;
	logic [32:0] dur;
	logic        long_enough;
	logic        visit;

	assign match      = valid_q && (note_q == cmd.note);
	assign first_free = !valid_q && !free_in;
	assign free_out   = free_in || !valid_q;
	assign match_out  = match_in || match;

	assign miss        = cmd.silent || !seen_q;
	assign hold_dec    = hold_q - 9'd1;
	assign close       = hold_dec[8] || (hold_dec == 9'd0);
	assign dur         = {1'b0, cmd.sweep_time} - {1'b0, start_q};
	assign long_enough = !dur[32] && (dur[31:0] >= cmd.min_len);
	assign emit        = valid_q && (cmd.flush || (miss && close)) && long_enough;
	assign later_out   = later_in || emit;

	assign visit = tok_q && adv;
	assign tok   = tok_q;
	assign note  = note_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seen_q  <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_take || (tok_q && !adv);
			if (cmd.clr_seen) begin
				seen_q <= 1'b0;
			end else if (cmd.note_op) begin
				if (match) begin
					seen_q <= 1'b1;
				end else if (cmd.alloc && first_free) begin
					valid_q <= 1'b1;
					seen_q  <= 1'b1;
				end
			end else if (visit) begin
				seen_q <= 1'b0;
				if (cmd.flush) begin
					valid_q <= 1'b0;
				end else if (valid_q && miss && close) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.note_op) begin
			if (match && !cmd.silent) begin
				hold_q <= {1'b0, cmd.hold};
			end else if (!match && cmd.alloc && first_free) begin
				note_q  <= cmd.note;
				start_q <= cmd.frame_time;
				hold_q  <= {1'b0, cmd.hold};
			end
		end else if (visit && !cmd.flush && valid_q && miss) begin
			hold_q <= hold_dec;
		end
	end

endmodule

`default_nettype wire

@@ hdl/polyphonic_note_event_tracker_unit.sv @@
// Polyphonic note event tracker: a chain of slot cells turning note detections into events.
// Frame start and note items keep the unit idle; the next item is taken when the output is free.
// A note-on is registered to the output in the cycle after the note is accepted. Frame end and
// flush are accepted, then sweep a token through the chain, one cell per cycle, holding while a
// note-off waits on a stalled output. No item is taken until the token leaves the last cell.
// Reset empties the table, clears seen marks, frame state and output, and loads register defaults.
// Depends on pnet_pkg and pnet_cell.
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_note_event_tracker_unit #(
	parameter int MAX_ACTIVE = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         s_tvalid,
	output logic        s_tready,
	// level[15:0], time_us[47:16], note_number[54:48], strength[61:55], zero[63:62]
	input  wire  [63:0] s_tdata,
	// kind[1:0]
	input  wire  [1:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// note_out[6:0], velocity_out[13:7], event_time[45:14], zero[47:46]
	output logic [47:0] m_tdata,
	// is_note_on[0]
	output logic        m_tuser,
	output logic        m_tlast
);
	import pnet_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_HOLD   = 2'd1;
	localparam logic [1:0] REG_MINLEN = 2'd2;

	state_t      state_q;
	logic [15:0] thresh_q;
	logic [7:0]  hold_q;
	logic [31:0] min_len_q;
	logic        silent_q;
	logic [31:0] frame_time_q;
	logic [31:0] sweep_time_q;
	logic        flush_q;

	logic        out_valid_q;
	logic        out_on_q;
	logic        out_last_q;
	logic [6:0]  out_note_q;
	logic [6:0]  out_vel_q;
	logic [31:0] out_time_q;

	logic        cfg_wr;
	logic        accept;
	logic        out_free;
	kind_t       kind;
	logic [15:0] in_level;
	logic [31:0] in_time;
	logic [6:0]  in_note;
	logic [6:0]  in_strength;
	logic [6:0]  note_clamped;

	cell_cmd_t   cmd;
	logic        note_on;
	logic        start_sweep;
	logic        adv;
	logic        stall;
	logic        sel_emit;
	logic        sel_last;
	logic [6:0]  sel_note;

	logic [MAX_ACTIVE-1:0] tok;
	logic [MAX_ACTIVE-1:0] tok_take;
	logic [MAX_ACTIVE-1:0] emit;
	logic [MAX_ACTIVE-1:0] free_in;
	logic [MAX_ACTIVE-1:0] free_out;
	logic [MAX_ACTIVE-1:0] match_in;
	logic [MAX_ACTIVE-1:0] match_out;
	logic [MAX_ACTIVE-1:0] later_in;
	logic [MAX_ACTIVE-1:0] later_out;
	logic [6:0]            cell_note [MAX_ACTIVE];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_THRESH: prdata = {16'd0, thresh_q};
			REG_HOLD:   prdata = {24'd0, hold_q};
			REG_MINLEN: prdata = min_len_q;
			default:    prdata = 32'd0;
		endcase
	end

	assign kind        = kind_t'(s_tuser);
	assign in_level    = s_tdata[15:0];
	assign in_time     = s_tdata[47:16];
	assign in_note     = s_tdata[54:48];
	assign in_strength = s_tdata[61:55];

	always_comb begin
		if (in_note < NOTE_LOW) begin
			note_clamped = NOTE_LOW;
		end else if (in_note > NOTE_HIGH) begin
			note_clamped = NOTE_HIGH;
		end else begin
			note_clamped = in_note;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign cmd.clr_seen   = accept && (kind == KIND_FRAME_START);
	assign cmd.note_op    = accept && (kind == KIND_NOTE);
	assign cmd.alloc      = !silent_q && !match_out[MAX_ACTIVE-1] && (in_strength != 7'd0);
	assign cmd.silent     = silent_q;
	assign cmd.flush      = flush_q;
	assign cmd.note       = note_clamped;
	assign cmd.hold       = hold_q;
	assign cmd.frame_time = frame_time_q;
	assign cmd.sweep_time = sweep_time_q;
	assign cmd.min_len    = min_len_q;

	assign note_on     = cmd.note_op && cmd.alloc && free_out[MAX_ACTIVE-1];
	assign start_sweep = accept && ((kind == KIND_FRAME_END) || (kind == KIND_FLUSH));

	always_comb begin
		sel_emit = 1'b0;
		sel_last = 1'b0;
		sel_note = 7'd0;
		for (int i = 0; i < MAX_ACTIVE; i++) begin
			if (tok[i]) begin
				sel_emit = sel_emit | emit[i];
				sel_last = sel_last | !later_in[i];
				sel_note = sel_note | cell_note[i];
			end
		end
	end

	assign stall = sel_emit && !out_free;
	assign adv   = (state_q == ST_SWEEP) && !stall;

	genvar g;
	generate
		for (g = 0; g < MAX_ACTIVE; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign tok_take[g] = start_sweep;
				assign free_in[g]  = 1'b0;
				assign match_in[g] = 1'b0;
			end else begin : g_body
				assign tok_take[g] = tok[g-1] && adv;
				assign free_in[g]  = free_out[g-1];
				assign match_in[g] = match_out[g-1];
			end
			if (g == MAX_ACTIVE - 1) begin : g_tail
				assign later_in[g] = 1'b0;
			end else begin : g_mid
				assign later_in[g] = later_out[g+1];
			end
			pnet_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.tok_take  (tok_take[g]),
				.adv       (adv),
				.free_in   (free_in[g]),
				.free_out  (free_out[g]),
				.match_in  (match_in[g]),
				.match_out (match_out[g]),
				.later_in  (later_in[g]),
				.later_out (later_out[g]),
				.tok       (tok[g]),
				.emit      (emit[g]),
				.note      (cell_note[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			thresh_q     <= 16'd328;
			hold_q       <= 8'd5;
			min_len_q    <= 32'd50000;
			silent_q     <= 1'b0;
			frame_time_q <= 32'd0;
			sweep_time_q <= 32'd0;
			flush_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_THRESH: thresh_q  <= pwdata[15:0];
					REG_HOLD:   hold_q    <= pwdata[7:0];
					REG_MINLEN: min_len_q <= pwdata;
					default:    ;
				endcase
			end
			if (accept && (kind == KIND_FRAME_START)) begin
				silent_q     <= in_level < thresh_q;
				frame_time_q <= in_time;
			end
			if (start_sweep) begin
				flush_q      <= (kind == KIND_FLUSH);
				sweep_time_q <= (kind == KIND_FLUSH) ? in_time : frame_time_q;
			end
			case (state_q)
				ST_IDLE: begin
					if (start_sweep) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (adv && tok[MAX_ACTIVE-1]) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (note_on || (adv && sel_emit)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (note_on) begin
			out_on_q   <= 1'b1;
			out_last_q <= 1'b1;
			out_note_q <= note_clamped;
			out_vel_q  <= in_strength;
			out_time_q <= frame_time_q;
		end else if (adv && sel_emit) begin
			out_on_q   <= 1'b0;
			out_last_q <= sel_last;
			out_note_q <= sel_note;
			out_vel_q  <= 7'd0;
			out_time_q <= sweep_time_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_time_q, out_vel_q, out_note_q};
	assign m_tuser  = out_on_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ bench/pnet_checker.sv @@
// Checker for the polyphonic note event tracker: watches the APB port and both streams.
// Keeps its own copy of the note table, predicts the events of every input transaction
// and compares each output transaction with the oldest prediction. Depends on pnet_pkg.
`timescale 1ns / 1ps

module pnet_checker #(
	parameter int MAX_ACTIVE = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [63:0] s_tdata,
	input  wire  [1:0]  s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [47:0] m_tdata,
	input  wire         m_tuser,
	input  wire         m_tlast,
	output int          mismatches,
	output int          outstanding
);
	import pnet_pkg::*;

	localparam logic [1:0] REG_SILENCE = 2'd0;
	localparam logic [1:0] REG_HOLD    = 2'd1;
	localparam logic [1:0] REG_MIN_LEN = 2'd2;

	typedef struct packed {
		logic        is_on;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [31:0] stamp;
		logic        last;
	} note_event_t;

	note_event_t expected_events[$];

	logic               slot_used [MAX_ACTIVE];
	logic [6:0]         slot_key  [MAX_ACTIVE];
	logic [31:0]        slot_born [MAX_ACTIVE];
	logic signed [9:0]  slot_life [MAX_ACTIVE];
	logic               slot_hit  [MAX_ACTIVE];
	logic               frame_quiet;
	logic [31:0]        frame_stamp;
	logic [15:0]        cfg_threshold;
	logic [7:0]         cfg_hold;
	logic [31:0]        cfg_min_len;

	function automatic logic lasted(input logic [31:0] born, input logic [31:0] now);
		if (now < born)
			return 1'b0;
		return (now - born) >= cfg_min_len;
	endfunction

	task automatic predict_events(input kind_t kind, input logic [15:0] level,
			input logic [31:0] t, input logic [6:0] raw_note, input logic [6:0] vel);
		note_event_t burst [MAX_ACTIVE];
		note_event_t ev;
		logic [6:0]  note;
		int          n;
		int          hit;
		int          free;
		n = 0;
		case (kind)
			KIND_FRAME_START: begin
				frame_quiet = level < cfg_threshold;
				frame_stamp = t;
			end
			KIND_NOTE: begin
				note = raw_note;
				if (note < NOTE_LOW)
					note = NOTE_LOW;
				if (note > NOTE_HIGH)
					note = NOTE_HIGH;
				hit = -1;
				for (int i = 0; i < MAX_ACTIVE; i++)
					if (hit < 0 && slot_used[i] && slot_key[i] == note)
						hit = i;
				if (hit >= 0)
					slot_hit[hit] = 1'b1;
				if (!frame_quiet) begin
					if (hit >= 0) begin
						slot_life[hit] = {2'b00, cfg_hold};
					end else if (vel != 0) begin
						free = -1;
						for (int i = 0; i < MAX_ACTIVE; i++)
							if (free < 0 && !slot_used[i])
								free = i;
						if (free >= 0) begin
							slot_used[free] = 1'b1;
							slot_key[free]  = note;
							slot_born[free] = frame_stamp;
							slot_life[free] = {2'b00, cfg_hold};
							slot_hit[free]  = 1'b1;
							burst[n] = '{1'b1, note, vel, frame_stamp, 1'b0};
							n++;
						end
					end
				end
			end
			KIND_FRAME_END: begin
				for (int i = 0; i < MAX_ACTIVE; i++) begin
					if (slot_used[i] && (frame_quiet || !slot_hit[i])) begin
						slot_life[i] = slot_life[i] - 1;
						if (slot_life[i] <= 0) begin
							if (lasted(slot_born[i], frame_stamp)) begin
								burst[n] = '{1'b0, slot_key[i], 7'd0, frame_stamp, 1'b0};
								n++;
							end
							slot_used[i] = 1'b0;
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < MAX_ACTIVE; i++) begin
					if (slot_used[i]) begin
						if (lasted(slot_born[i], t)) begin
							burst[n] = '{1'b0, slot_key[i], 7'd0, t, 1'b0};
							n++;
						end
						slot_used[i] = 1'b0;
					end
				end
			end
		endcase
		if (kind != KIND_NOTE)
			for (int i = 0; i < MAX_ACTIVE; i++)
				slot_hit[i] = 1'b0;
		for (int k = 0; k < n; k++) begin
			ev = burst[k];
			ev.last = (k == n - 1);
			expected_events.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		note_event_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ACTIVE; i++) begin
				slot_used[i] = 1'b0;
				slot_key[i]  = '0;
				slot_born[i] = '0;
				slot_life[i] = '0;
				slot_hit[i]  = 1'b0;
			end
			frame_quiet   = 1'b0;
			frame_stamp   = '0;
			cfg_threshold = 16'd328;
			cfg_hold      = 8'd5;
			cfg_min_len   = 32'd50000;
			expected_events.delete();
			mismatches    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SILENCE: cfg_threshold = pwdata[15:0];
					REG_HOLD:    cfg_hold      = pwdata[7:0];
					REG_MIN_LEN: cfg_min_len   = pwdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_events(kind_t'(s_tuser), s_tdata[15:0], s_tdata[47:16],
					s_tdata[54:48], s_tdata[61:55]);
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event: note_out %0d, event_time %0d",
						m_tdata[6:0], m_tdata[45:14]);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					if (m_tuser !== want.is_on) begin
						$error("is_note_on: expected %0d, actual %0d", want.is_on, m_tuser);
						mismatches++;
					end
					if (m_tdata[6:0] !== want.note) begin
						$error("note_out: expected %0d, actual %0d", want.note, m_tdata[6:0]);
						mismatches++;
					end
					if (m_tdata[13:7] !== want.vel) begin
						$error("velocity_out: expected %0d, actual %0d", want.vel,
							m_tdata[13:7]);
						mismatches++;
					end
					if (m_tdata[45:14] !== want.stamp) begin
						$error("event_time: expected %0d, actual %0d", want.stamp,
							m_tdata[45:14]);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, m_tlast);
						mismatches++;
					end
				end
			end
		end
		outstanding = expected_events.size();
	end

endmodule

@@ bench/tb.sv @@
// Top of the note event tracker bench: clock, reset, APB register writes and stream stimulus.
// Runs a directed sequence, then random frames under several register settings with random
// stalls on both streams. Depends on pnet_pkg, the tracker and pnet_checker.
`timescale 1ns / 1ps

module tb;
	import pnet_pkg::*;

	localparam logic [3:0] ADDR_SILENCE = 4'd0;
	localparam logic [3:0] ADDR_HOLD    = 4'd4;
	localparam logic [3:0] ADDR_MIN_LEN = 4'd8;
	localparam logic [3:0] ADDR_SPARE   = 4'd12;
	localparam int QUIET_LIMIT = 5000;
	localparam int SWEEP_SLACK = 40;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [63:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [47:0] m_tdata;
	wire         m_tuser;
	wire         m_tlast;

	int          mismatches;
	int          outstanding;
	int          quiet_cycles = 0;
	int          ready_hold   = 0;
	int          sent         = 0;
	bit          steady       = 1'b0;
	logic [15:0] threshold    = 16'd328;
	logic [31:0] clock_us     = '0;

	polyphonic_note_event_tracker_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	pnet_checker watcher (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			ready_hold <= gap_len() - 1;
		end else begin
			m_tready   <= 1'b1;
			ready_hold <= $urandom_range(0, 6);
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic send_item(input kind_t kind, input logic [15:0] level, input logic [31:0] t,
			input logic [6:0] note, input logic [6:0] vel);
		int gap;
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap)
				@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = {2'b00, vel, note, t, level};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	// Waits for every predicted event, then for the sweep of an item that produced none.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SWEEP_SLACK)
			@(negedge clk);
	endtask

	task automatic configure(input logic [15:0] thr, input logic [7:0] hold,
			input logic [31:0] min_len);
		drain();
		reg_write(ADDR_SILENCE, {16'd0, thr});
		reg_write(ADDR_HOLD, {24'd0, hold});
		reg_write(ADDR_MIN_LEN, min_len);
		threshold = thr;
	endtask

	function automatic logic [15:0] pick_level();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		if (threshold != 0 && $urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, threshold - 1));
		return 16'($urandom_range(threshold, 16'hFFFF));
	endfunction

	function automatic logic [6:0] pick_note();
		if ($urandom_range(0, 99) < 85)
			return 7'($urandom_range(44, 64));
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic logic [6:0] pick_strength();
		if ($urandom_range(0, 5) == 0)
			return 7'd0;
		return 7'($urandom_range(1, 127));
	endfunction

	// Mostly whole frames with random content; some frames stay open, some items are noise.
	task automatic run_frames(input int budget);
		int first;
		int notes;
		int r;
		int tail;
		first = sent;
		while (sent - first < budget) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				clock_us = clock_us + $urandom_range(2000, 30000);
				if ($urandom_range(0, 19) == 0)
					clock_us = $urandom;
				send_item(KIND_FRAME_START, pick_level(), clock_us, 7'($urandom),
					7'($urandom));
				notes = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
					: $urandom_range(0, 5);
				repeat (notes)
					send_item(KIND_NOTE, 16'($urandom), $urandom, pick_note(),
						pick_strength());
				tail = $urandom_range(0, 19);
				if (tail < 17)
					send_item(KIND_FRAME_END, 16'($urandom), $urandom, 7'($urandom),
						7'($urandom));
				else if (tail < 19)
					send_item(KIND_FLUSH, 16'($urandom),
						clock_us + $urandom_range(0, 100000), 7'($urandom), 7'($urandom));
			end else if (r < 97) begin
				send_item(kind_t'($urandom_range(0, 3)), 16'($urandom), $urandom,
					7'($urandom), 7'($urandom));
			end else begin
				drain();
			end
			if ($urandom_range(0, 29) == 0)
				steady = ~steady;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Note and frame end before any frame start, under the reset defaults.
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd0, 7'd127);
		send_item(KIND_FRAME_END, 16'd0, 32'd0, 7'd0, 7'd0);
		// A silent frame only marks entries as seen and then ages all of them.
		send_item(KIND_FRAME_START, 16'd0, 32'hFFFF_FFFF, 7'd0, 7'd0);
		send_item(KIND_NOTE, 16'hFFFF, 32'hFFFF_FFFF, 7'd127, 7'd1);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd21, 7'd0);
		send_item(KIND_FRAME_END, 16'd0, 32'd0, 7'd0, 7'd0);
		// Zero strength without an entry does nothing; with one it refreshes.
		send_item(KIND_FRAME_START, 16'hFFFF, 32'd100, 7'd0, 7'd0);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd60, 7'd0);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd20, 7'd0);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd108, 7'd127);
		// Flush at a time too short for one entry and earlier than the other.
		send_item(KIND_FLUSH, 16'd0, 32'd0, 7'd0, 7'd0);

		configure(16'd328, 8'd0, 32'd0);
		send_item(KIND_FRAME_START, 16'd328, 32'd5, 7'd0, 7'd0);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd64, 7'd64);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd64, 7'd100);
		send_item(KIND_FRAME_END, 16'd0, 32'd0, 7'd0, 7'd0);
		send_item(KIND_FRAME_START, 16'd327, 32'd4, 7'd0, 7'd0);
		send_item(KIND_FRAME_END, 16'd0, 32'd0, 7'd0, 7'd0);
		send_item(KIND_FRAME_START, 16'h8000, 32'd1000, 7'd0, 7'd0);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd30, 7'd10);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd31, 7'd20);
		send_item(KIND_NOTE, 16'd0, 32'd0, 7'd32, 7'd127);
		send_item(KIND_FRAME_END, 16'd0, 32'd0, 7'd0, 7'd0);
		send_item(KIND_FRAME_END, 16'd0, 32'd0, 7'd0, 7'd0);

		configure(16'($urandom_range(200, 2000)), 8'($urandom_range(1, 4)),
			$urandom_range(0, 60000));
		run_frames(110);

		configure(16'd0, 8'd255, 32'hFFFF_FFFF);
		reg_write(ADDR_SPARE, $urandom);
		run_frames(90);

		configure(16'hFFFF, 8'd0, 32'd0);
		run_frames(70);

		configure(16'($urandom), 8'($urandom_range(0, 12)),
			($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 80000));
		run_frames(140);

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
